>>> sv/isp_pkg.sv
// Shared widths, codes and controller/datapath handshake types for the spin update core.
`default_nettype none
package isp_pkg;

  // Item, result and configuration field widths
  localparam int unsigned KIND_W = 2;
  localparam int unsigned COORD_W = 5;
  localparam int unsigned RAND_W = 16;
  localparam int unsigned DE_W = 5;
  localparam int unsigned THR_W = 17;
  localparam int unsigned CFG_IDX_W = 2;

  // Item kinds (any other code reads)
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRIAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_EIGHT = 2'd1;

  // Row select for the lattice read port
  localparam logic [1:0] ROW_UP = 2'd0;
  localparam logic [1:0] ROW_DN = 2'd1;
  localparam logic [1:0] ROW_MID = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;    // latch the accepted item
    logic       rd_en;   // issue a lattice row read
    logic [1:0] rd_sel;  // which row to read
    logic       cap_up;  // capture the upper neighbor bit
    logic       cap_dn;  // capture the lower neighbor bit
    logic       commit;  // write the row back and load the result
  } isp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_trial;
  } isp_sts_t;

endpackage
`default_nettype wire

>>> sv/isp_if.sv
// Channel interfaces: input items, result items and configuration writes.
`default_nettype none
interface isp_in_if;
  logic                         valid;
  logic                         ready;
  logic [isp_pkg::KIND_W-1:0]   kind;
  logic [isp_pkg::COORD_W-1:0]  row;
  logic [isp_pkg::COORD_W-1:0]  col;
  logic                         spin_value;
  logic [isp_pkg::RAND_W-1:0]   random_fraction;

  modport source (output valid, kind, row, col, spin_value, random_fraction, input ready);
  modport sink (input valid, kind, row, col, spin_value, random_fraction, output ready);
endinterface

interface isp_out_if;
  logic                           valid;
  logic                           ready;
  logic                           spin_up;
  logic                           flipped;
  logic signed [isp_pkg::DE_W-1:0] energy_change;

  modport source (output valid, spin_up, flipped, energy_change, input ready);
  modport sink (input valid, spin_up, flipped, energy_change, output ready);
endinterface

interface isp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [isp_pkg::CFG_IDX_W-1:0]  index;
  logic [isp_pkg::THR_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/isp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module isp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/isp_ctrl.sv
// Sequencer: item acceptance, row read order, write-back and result valid.
`default_nettype none
module isp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      isp_pkg::isp_cmd_t cmd,
  input  wire isp_pkg::isp_sts_t sts
);
  import isp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_DN   = 3'd2;
  localparam logic [2:0] S_MID  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;
  logic       out_valid_next;
  logic       slot_free;

  // result register free this cycle
  assign slot_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rd_sel = ROW_MID;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_UP;
        end
      end
      S_UP: begin
        cmd.rd_en = 1'b1;
        if (sts.is_trial) begin
          cmd.rd_sel = ROW_UP;
          state_next = S_DN;
        end else begin
          cmd.rd_sel = ROW_MID;
          state_next = S_DONE;
        end
      end
      S_DN: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = ROW_DN;
        cmd.cap_up = 1'b1;
        state_next = S_MID;
      end
      S_MID: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = ROW_MID;
        cmd.cap_dn = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result valid: set on commit, cleared when taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/isp_dp.sv
// Datapath: lattice row store, thresholds, neighbor capture, acceptance and result register.
`default_nettype none
module isp_dp #(
  parameter int unsigned SIDE = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire isp_pkg::isp_cmd_t             cmd,
  output      isp_pkg::isp_sts_t             sts,
  input  wire logic [isp_pkg::KIND_W-1:0]    kind,
  input  wire logic [isp_pkg::COORD_W-1:0]   row,
  input  wire logic [isp_pkg::COORD_W-1:0]   col,
  input  wire logic                          spin_value,
  input  wire logic [isp_pkg::RAND_W-1:0]    random_fraction,
  input  wire logic                          cfg_we,
  input  wire logic [isp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [isp_pkg::THR_W-1:0]     cfg_data,
  output      logic                          spin_up,
  output      logic                          flipped,
  output      logic signed [isp_pkg::DE_W-1:0] energy_change
);
  import isp_pkg::*;

  localparam int unsigned IW = $clog2(SIDE);
  localparam int unsigned LUT_N = 2 ** COORD_W;
  localparam logic [IW-1:0] LAST = IW'(SIDE - 1);

  // coordinate reduction modulo SIDE, built at elaboration
  logic [IW-1:0] mod_lut [LUT_N];
  for (genvar i = 0; i < LUT_N; i++) begin : g_mod
    assign mod_lut[i] = IW'(i % SIDE);
  end

  // latched item
  logic [KIND_W-1:0] kind_q;
  logic [IW-1:0]     r_q;
  logic [IW-1:0]     c_q;
  logic              spin_q;
  logic [RAND_W-1:0] rnd_q;

  // thresholds
  logic [THR_W-1:0] thr_four;
  logic [THR_W-1:0] thr_eight;

  // row store and per-row written flags (unwritten rows read as all +1)
  logic [SIDE-1:0] row_written;
  logic            rd_written;
  logic [IW-1:0]   raddr;
  logic [SIDE-1:0] rdata;
  logic [SIDE-1:0] row_data;
  logic [SIDE-1:0] wdata;

  // neighbor bits and trial logic
  logic          up_bit;
  logic          dn_bit;
  logic [IW-1:0] rp, rm, cp, cm;
  logic          s_bit;
  logic [2:0]    n_eq;
  logic          accept;
  logic          is_trial;
  logic          is_write;
  logic          new_bit;
  logic [DE_W-1:0] de;

  assign is_trial = (kind_q == KIND_TRIAL);
  assign is_write = (kind_q == KIND_WRITE);
  assign sts.is_trial = is_trial;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      r_q <= mod_lut[row];
      c_q <= mod_lut[col];
      spin_q <= spin_value;
      rnd_q <= random_fraction;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_four <= '0;
      thr_eight <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_THR_FOUR) begin
        thr_four <= cfg_data;
      end else if (cfg_index == REG_THR_EIGHT) begin
        thr_eight <= cfg_data;
      end
    end
  end

  // periodic neighbor coordinates
  assign rp = (r_q == LAST) ? '0 : r_q + 1'b1;
  assign rm = (r_q == '0) ? LAST : r_q - 1'b1;
  assign cp = (c_q == LAST) ? '0 : c_q + 1'b1;
  assign cm = (c_q == '0) ? LAST : c_q - 1'b1;

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      ROW_UP:  raddr = rm;
      ROW_DN:  raddr = rp;
      default: raddr = r_q;
    endcase
  end

  isp_ram #(
    .WIDTH(SIDE),
    .DEPTH(SIDE)
  ) u_lattice (
    .clk  (clk),
    .we   (cmd.commit),
    .waddr(r_q),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  // written flags: cleared by reset, set by any write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
    end else if (cmd.commit) begin
      row_written[r_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_written <= row_written[raddr];
    end
  end

  assign row_data = rd_written ? rdata : '1;

  // neighbor bits from the rows above and below
  always_ff @(posedge clk) begin
    if (cmd.cap_up) begin
      up_bit <= row_data[c_q];
    end
    if (cmd.cap_dn) begin
      dn_bit <= row_data[c_q];
    end
  end

  // dE = 4 * (neighbors equal to the site) - 8
  assign s_bit = row_data[c_q];
  assign n_eq = 3'(up_bit == s_bit) + 3'(dn_bit == s_bit)
              + 3'(row_data[cp] == s_bit) + 3'(row_data[cm] == s_bit);
  assign de = DE_W'({n_eq, 2'b00}) - DE_W'(8);

  always_comb begin
    if (n_eq <= 3'd2) begin
      accept = 1'b1;
    end else if (n_eq == 3'd3) begin
      accept = {1'b0, rnd_q} < thr_four;
    end else begin
      accept = {1'b0, rnd_q} < thr_eight;
    end
  end

  // new site bit and row write-back data
  always_comb begin
    new_bit = s_bit;
    if (is_write) begin
      new_bit = spin_q;
    end else if (is_trial) begin
      new_bit = s_bit ^ accept;
    end
    wdata = row_data;
    wdata[c_q] = new_bit;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      spin_up <= new_bit;
      flipped <= is_trial && accept;
      energy_change <= is_trial ? signed'(de) : '0;
    end
  end

endmodule
`default_nettype wire

>>> sv/ising_metropolis_spin_update_core.sv
// Top level of the Ising Metropolis spin update core.
//
//   channel     dir  handshake      payload
//   item_in     in   valid/ready    kind, row, col, spin_value, random_fraction
//   result_out  out  valid/ready    spin_up, flipped, energy_change
//   cfg         in   valid/ready    index, data (threshold registers)
//
// A write or read item reads only its own row; a trial reads one lattice row per
// cycle through the single read port of the row store (rows above, below, own).
// Results wait in an output register; a stalled result holds the next item in
// its last cycle. Reset clears the thresholds and the per-row written flags at
// once, so every spin reads +1 right after reset. Configuration is always ready.
`default_nettype none
module ising_metropolis_spin_update_core #(
  parameter int unsigned SIDE = 32
) (
  input wire logic clk,
  input wire logic rst,
  isp_in_if.sink   item_in,
  isp_out_if.source result_out,
  isp_cfg_if.sink  cfg
);
  import isp_pkg::*;

  isp_cmd_t cmd;
  isp_sts_t sts;

  assign cfg.ready = 1'b1;

  isp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .out_valid(result_out.valid),
    .out_ready(result_out.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  isp_dp #(
    .SIDE(SIDE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .kind           (item_in.kind),
    .row            (item_in.row),
    .col            (item_in.col),
    .spin_value     (item_in.spin_value),
    .random_fraction(item_in.random_fraction),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .spin_up        (result_out.spin_up),
    .flipped        (result_out.flipped),
    .energy_change  (result_out.energy_change)
  );

endmodule
`default_nettype wire

>>> sim/ising_metropolis_spin_update_core_test.sv
// Self-checking testbench for the Ising Metropolis spin update core.
`timescale 1ns / 100ps
`default_nettype none
module ising_metropolis_spin_update_core_test;
  import isp_pkg::*;

  localparam int SIDE = 32;
  localparam int SITES = SIDE * SIDE;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 250;
  localparam int PHASES = 8;
  localparam int DRAIN_CYCLES = 12;

  // Codes the package leaves unnamed, and threshold and random extremes
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [THR_W-1:0] THR_ALWAYS = 17'd65536;
  localparam logic [THR_W-1:0] THR_MAX = 17'h1FFFF;
  localparam logic [RAND_W-1:0] RAND_MAX = 16'hFFFF;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               spin_value;
    logic [RAND_W-1:0]  random_fraction;
  } spin_item_t;

  typedef struct packed {
    logic                   spin_up;
    logic                   flipped;
    logic signed [DE_W-1:0] energy_change;
  } spin_result_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  isp_in_if  item_if ();
  isp_out_if result_if ();
  isp_cfg_if cfg_if ();

  ising_metropolis_spin_update_core #(.SIDE(SIDE)) u_top (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_if),
    .result_out(result_if),
    .cfg       (cfg_if)
  );

  always #5 clk = ~clk;

  // Predictor state: lattice copy and acceptance thresholds
  bit             lattice [SITES];
  logic [THR_W-1:0] thr_four = '0;
  logic [THR_W-1:0] thr_eight = '0;

  spin_item_t   spin_pending_q [$];
  spin_result_t spin_expect_q [$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  bit           item_fire = 1'b0;

  function automatic int spin_sign(input int r, input int c);
    return lattice[(r % SIDE) * SIDE + (c % SIDE)] ? 1 : -1;
  endfunction

  // Applies one item to the lattice copy and returns the result it causes
  task automatic apply_spin_item(input spin_item_t it, output spin_result_t res);
    int  r;
    int  c;
    int  idx;
    int  nsum;
    int  de;
    bit  take;
    r = it.row % SIDE;
    c = it.col % SIDE;
    idx = r * SIDE + c;
    res = '0;
    case (it.kind)
      KIND_WRITE: begin
        lattice[idx] = it.spin_value;
      end
      KIND_TRIAL: begin
        nsum = spin_sign(r + 1, c) + spin_sign(r + SIDE - 1, c)
             + spin_sign(r, c + 1) + spin_sign(r, c + SIDE - 1);
        de = 2 * spin_sign(r, c) * nsum;
        if (de <= 0) take = 1'b1;
        else if (de == 4) take = ({1'b0, it.random_fraction} < thr_four);
        else take = ({1'b0, it.random_fraction} < thr_eight);
        if (take) lattice[idx] = ~lattice[idx];
        res.flipped = take;
        res.energy_change = DE_W'(de);
      end
      default: ;
    endcase
    res.spin_up = lattice[idx];
  endtask

  function automatic spin_item_t mk_item(input logic [KIND_W-1:0] kind, input int r, input int c,
                                         input bit s, input logic [RAND_W-1:0] rnd);
    spin_item_t it;
    it.kind = kind;
    it.row = COORD_W'(r);
    it.col = COORD_W'(c);
    it.spin_value = s;
    it.random_fraction = rnd;
    return it;
  endfunction

  // Random item, mostly confined to a small window so writes shape the trials
  function automatic spin_item_t random_spin_item(input logic [COORD_W-1:0] wr,
                                                  input logic [COORD_W-1:0] wc);
    spin_item_t it;
    int unsigned pick;
    logic [THR_W-1:0] near;
    pick = $urandom_range(0, 9);
    if (pick < 3) it.kind = KIND_WRITE;
    else if (pick < 8) it.kind = KIND_TRIAL;
    else if (pick == 8) it.kind = KIND_READ;
    else it.kind = KIND_SPARE;
    if ($urandom_range(0, 3) != 0) begin
      it.row = wr + COORD_W'($urandom_range(0, 3));
      it.col = wc + COORD_W'($urandom_range(0, 3));
    end else begin
      it.row = COORD_W'($urandom);
      it.col = COORD_W'($urandom);
    end
    it.spin_value = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 15);
    near = ($urandom_range(0, 1) != 0) ? thr_four : thr_eight;
    if (pick == 0) it.random_fraction = '0;
    else if (pick == 1) it.random_fraction = RAND_MAX;
    else if (pick == 2) it.random_fraction = (near > RAND_MAX) ? RAND_MAX : near[RAND_W-1:0];
    else if (pick == 3) it.random_fraction = (near == 0) ? '0 : RAND_W'(near - 1);
    else it.random_fraction = RAND_W'($urandom);
    return it;
  endfunction

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] index, input logic [THR_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (index == REG_THR_FOUR) thr_four = value;
    else if (index == REG_THR_EIGHT) thr_eight = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Waits until every queued item has gone in and every result has come back
  task automatic drain_items();
    while (spin_pending_q.size() != 0 || item_if.valid || spin_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts of items with random gaps between them
  int         burst_left = 0;
  int         gap_left = 0;
  spin_item_t drive_item;

  always @(negedge clk) begin
    if (!item_if.valid || item_fire) begin
      if (gap_left > 0 || spin_pending_q.size() == 0) begin
        item_if.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        drive_item = spin_pending_q.pop_front();
        item_if.valid <= 1'b1;
        item_if.kind <= drive_item.kind;
        item_if.row <= drive_item.row;
        item_if.col <= drive_item.col;
        item_if.spin_value <= drive_item.spin_value;
        item_if.random_fraction <= drive_item.random_fraction;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: stall pattern that switches between random modes
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_seg = 0;

  always @(negedge clk) begin
    if (stall_seg == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_seg = $urandom_range(20, 200);
    end
    stall_seg--;
    case (stall_mode)
      STALL_NONE: result_if.ready <= 1'b1;
      STALL_COIN: result_if.ready <= ($urandom_range(0, 1) != 0);
      default:    result_if.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Monitor: predict on accepted items, check accepted results
  always @(posedge clk) begin : check_results
    spin_item_t   acc;
    spin_result_t want;
    item_fire <= item_if.valid && item_if.ready;
    if (!rst && item_if.valid && item_if.ready) begin
      acc = mk_item(item_if.kind, int'(item_if.row), int'(item_if.col), item_if.spin_value,
                    item_if.random_fraction);
      apply_spin_item(acc, want);
      spin_expect_q.push_back(want);
    end
    if (!rst && result_if.valid && result_if.ready) begin
      if (spin_expect_q.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        want = spin_expect_q.pop_front();
        if (result_if.spin_up !== want.spin_up) begin
          $error("spin_up: expected %0d, got %0d", want.spin_up, result_if.spin_up);
          fail_count++;
        end
        if (result_if.flipped !== want.flipped) begin
          $error("flipped: expected %0d, got %0d", want.flipped, result_if.flipped);
          fail_count++;
        end
        if (result_if.energy_change !== want.energy_change) begin
          $error("energy_change: expected %0d, got %0d", want.energy_change,
                 result_if.energy_change);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus sequence
  logic [THR_W-1:0]   phase_four [PHASES];
  logic [THR_W-1:0]   phase_eight [PHASES];
  logic [COORD_W-1:0] win_row;
  logic [COORD_W-1:0] win_col;

  initial begin
    item_if.valid = 1'b0;
    item_if.kind = KIND_READ;
    item_if.row = '0;
    item_if.col = '0;
    item_if.spin_value = 1'b0;
    item_if.random_fraction = '0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_THR_FOUR;
    cfg_if.data = '0;
    foreach (lattice[i]) lattice[i] = 1'b1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: corners, wrap neighbors and every sign of dE at reset thresholds
    spin_pending_q.push_back(mk_item(KIND_READ, 0, 0, 1'b0, 16'd0));
    spin_pending_q.push_back(mk_item(KIND_SPARE, SIDE - 1, SIDE - 1, 1'b1, RAND_MAX));
    spin_pending_q.push_back(mk_item(KIND_TRIAL, SIDE - 1, SIDE - 1, 1'b0, 16'd0));
    spin_pending_q.push_back(mk_item(KIND_WRITE, 0, 0, 1'b0, RAND_MAX));
    spin_pending_q.push_back(mk_item(KIND_READ, 0, 0, 1'b1, 16'd0));
    spin_pending_q.push_back(mk_item(KIND_TRIAL, 0, 0, 1'b0, RAND_MAX));  // dE -8
    spin_pending_q.push_back(mk_item(KIND_TRIAL, 0, 0, 1'b0, 16'd0));     // dE +8, held
    spin_pending_q.push_back(mk_item(KIND_WRITE, 0, 1, 1'b0, 16'd0));
    spin_pending_q.push_back(mk_item(KIND_WRITE, 0, SIDE - 1, 1'b0, 16'd0));
    spin_pending_q.push_back(mk_item(KIND_TRIAL, 0, 0, 1'b1, 16'd0));     // dE 0
    spin_pending_q.push_back(mk_item(KIND_WRITE, 1, 0, 1'b0, 16'd0));
    spin_pending_q.push_back(mk_item(KIND_TRIAL, 0, 0, 1'b0, 16'd0));     // dE +4, held
    spin_pending_q.push_back(mk_item(KIND_WRITE, 0, 0, 1'b1, 16'd0));
    spin_pending_q.push_back(mk_item(KIND_TRIAL, 0, 0, 1'b0, 16'd0));     // dE -4
    spin_pending_q.push_back(mk_item(KIND_WRITE, SIDE - 1, 0, 1'b0, 16'd0));
    spin_pending_q.push_back(mk_item(KIND_TRIAL, SIDE - 1, SIDE - 1, 1'b1, RAND_MAX));
    spin_pending_q.push_back(mk_item(KIND_READ, SIDE - 1, 0, 1'b0, 16'd0));
    spin_pending_q.push_back(mk_item(KIND_SPARE, 0, 0, 1'b0, 16'd0));
    drain_items();

    // Threshold settings per phase, extremes first
    phase_four[0] = '0;         phase_eight[0] = '0;
    phase_four[1] = THR_ALWAYS; phase_eight[1] = THR_ALWAYS;
    phase_four[2] = 17'd32768;  phase_eight[2] = 17'd4096;
    phase_four[3] = THR_MAX;    phase_eight[3] = '0;
    phase_four[4] = 17'd1;      phase_eight[4] = 17'd65535;
    phase_four[5] = 17'd65535;  phase_eight[5] = THR_MAX;
    for (int p = 6; p < PHASES; p++) begin
      phase_four[p] = THR_W'($urandom_range(0, 65536));
      phase_eight[p] = THR_W'($urandom_range(0, 65536));
    end

    for (int p = 0; p < PHASES; p++) begin
      write_threshold(REG_THR_FOUR, phase_four[p]);
      write_threshold(REG_THR_EIGHT, phase_eight[p]);
      // Spare indexes must leave both thresholds alone
      if (p % 2 == 0) write_threshold(REG_SPARE_A, THR_W'($urandom));
      else write_threshold(REG_SPARE_B, THR_W'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 16 == 0) begin
          win_row = COORD_W'($urandom);
          win_col = COORD_W'($urandom);
        end
        spin_pending_q.push_back(random_spin_item(win_row, win_col));
      end
      drain_items();
    end

    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

>>> ising_metropolis_spin_update_core.f
sv/isp_pkg.sv
sv/isp_if.sv
sv/isp_ram.sv
sv/isp_ctrl.sv
sv/isp_dp.sv
sv/ising_metropolis_spin_update_core.sv
sim/ising_metropolis_spin_update_core_test.sv
